// File: rtl/oma_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// oma_pkg: shared types and constants for the overpower majority alarm
// Field widths, register indexes and reset values, plus the register groups
// handed from the top level to the front and back units.
// ----------------------------------------------------------------------------
package oma_pkg;

    localparam int MV_W        = 14;
    localparam int MA_W        = 14;
    localparam int DIFF_W      = 15;
    localparam int PROD_W      = 30;
    localparam int AVG_W       = 29;
    localparam int LIMIT_W     = 28;
    localparam int OVER_OUT_W  = 6;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 28;

    localparam logic [CFG_IDX_W-1:0] CFG_NOMINAL_HIGH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NOMINAL_LOW  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_HIGH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_LOW    = 3'd3;

    localparam logic [MV_W-1:0]    RST_NOMINAL_HIGH = 14'd12000;
    localparam logic [MV_W-1:0]    RST_NOMINAL_LOW  = 14'd5000;
    localparam logic [LIMIT_W-1:0] RST_LIMIT_HIGH   = 28'd70000000;
    localparam logic [LIMIT_W-1:0] RST_LIMIT_LOW    = 28'd35000000;

    typedef struct packed {
        logic [MV_W-1:0] nominal_high;
        logic [MV_W-1:0] nominal_low;
    } nominal_t;

    typedef struct packed {
        logic [LIMIT_W-1:0] limit_high;
        logic [LIMIT_W-1:0] limit_low;
    } limits_t;

endpackage
`default_nettype wire

// File: rtl/oma_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// oma_queue: two-entry window queue
// Holds closed-window sums between the front and back units.
// ----------------------------------------------------------------------------
module oma_queue #(
    parameter int DATA_W = 106
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push_valid,
    output logic                   push_ready,
    input  wire logic [DATA_W-1:0] push_data,
    output logic                   pop_valid,
    input  wire logic              pop_ready,
    output logic [DATA_W-1:0]      pop_data
);

    logic [DATA_W-1:0] entry_reg [2];
    logic              wr_ptr_reg;
    logic              wr_ptr_next;
    logic              rd_ptr_reg;
    logic              rd_ptr_next;
    logic [1:0]        fill_reg;
    logic [1:0]        fill_next;
    logic              push;
    logic              pop;

    assign push_ready = (fill_reg != 2'd2);
    assign pop_valid  = (fill_reg != 2'd0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + 2'd1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

// File: rtl/oma_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// oma_front: sample intake and window accumulation
// Forms both rail dissipations, adds them into the window sums and hands
// the sums of each closed window to the queue.
// ----------------------------------------------------------------------------
module oma_front import oma_pkg::*; #(
    parameter int COUNT_BITS = 16,
    parameter int SUM_W      = 45
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic                  s_mode,
    input  wire logic [MV_W-1:0]       s_high_rail_mv,
    input  wire logic [MA_W-1:0]       s_high_rail_ma,
    input  wire logic [MV_W-1:0]       s_low_rail_mv,
    input  wire logic [MA_W-1:0]       s_low_rail_ma,
    input  wire nominal_t              nominal,
    output logic                       q_valid,
    input  wire logic                  q_ready,
    output logic [2*SUM_W+COUNT_BITS-1:0] q_data
);

    localparam logic [COUNT_BITS-1:0] CAP = {COUNT_BITS{1'b1}};

    logic signed [DIFF_W-1:0] diff_high;
    logic signed [DIFF_W-1:0] diff_low;
    logic signed [DIFF_W-1:0] ma_high;
    logic signed [DIFF_W-1:0] ma_low;
    logic signed [PROD_W-1:0] prod_high;
    logic signed [PROD_W-1:0] prod_low;

    logic                     p_valid_reg;
    logic                     p_mode_reg;
    logic signed [PROD_W-1:0] p_high_reg;
    logic signed [PROD_W-1:0] p_low_reg;

    logic [SUM_W-1:0]         high_sum_reg;
    logic [SUM_W-1:0]         high_sum_next;
    logic [SUM_W-1:0]         low_sum_reg;
    logic [SUM_W-1:0]         low_sum_next;
    logic [COUNT_BITS-1:0]    count_reg;
    logic [COUNT_BITS-1:0]    count_next;
    logic                     take;
    logic                     acc_fire;
    logic                     accept;

    assign diff_high = $signed({1'b0, nominal.nominal_high}) - $signed({1'b0, s_high_rail_mv});
    assign diff_low  = $signed({1'b0, nominal.nominal_low}) - $signed({1'b0, s_low_rail_mv});
    assign ma_high   = $signed({1'b0, s_high_rail_ma});
    assign ma_low    = $signed({1'b0, s_low_rail_ma});
    assign prod_high = PROD_W'(diff_high) * PROD_W'(ma_high);
    assign prod_low  = PROD_W'(diff_low) * PROD_W'(ma_low);

    assign acc_fire = p_valid_reg && (!p_mode_reg || q_ready);
    assign s_ready  = !p_valid_reg || acc_fire;
    assign accept   = s_valid && s_ready;
    assign take     = (count_reg != CAP);

    always_comb begin
        high_sum_next = high_sum_reg;
        low_sum_next  = low_sum_reg;
        count_next    = count_reg;
        if (take) begin
            high_sum_next = high_sum_reg
                          + {{(SUM_W-PROD_W){p_high_reg[PROD_W-1]}}, p_high_reg};
            low_sum_next  = low_sum_reg
                          + {{(SUM_W-PROD_W){p_low_reg[PROD_W-1]}}, p_low_reg};
            count_next    = count_reg + COUNT_BITS'(1);
        end
    end

    assign q_valid = p_valid_reg && p_mode_reg;
    assign q_data  = {high_sum_next, low_sum_next, count_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg  <= 1'b0;
            high_sum_reg <= '0;
            low_sum_reg  <= '0;
            count_reg    <= '0;
        end else begin
            if (accept) begin
                p_valid_reg <= 1'b1;
            end else if (acc_fire) begin
                p_valid_reg <= 1'b0;
            end
            if (acc_fire) begin
                if (p_mode_reg) begin
                    high_sum_reg <= '0;
                    low_sum_reg  <= '0;
                    count_reg    <= '0;
                end else begin
                    high_sum_reg <= high_sum_next;
                    low_sum_reg  <= low_sum_next;
                    count_reg    <= count_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p_mode_reg <= s_mode;
            p_high_reg <= prod_high;
            p_low_reg  <= prod_low;
        end
    end

endmodule
`default_nettype wire

// File: rtl/oma_divider.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// oma_divider: serial signed-by-unsigned divider
// Restoring division of the dividend magnitude, one quotient bit per cycle,
// with the sign applied at the end so the result truncates toward zero.
// ----------------------------------------------------------------------------
module oma_divider #(
    parameter int DIVIDEND_W = 45,
    parameter int DIVISOR_W  = 16,
    parameter int QUOT_W     = 29
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         start,
    input  wire logic [DIVIDEND_W-1:0]        dividend,
    input  wire logic [DIVISOR_W-1:0]         divisor,
    output logic                              busy,
    output logic signed [QUOT_W-1:0]          quotient
);

    localparam int STEP_W = $clog2(DIVIDEND_W + 1);

    logic                   busy_reg;
    logic [STEP_W-1:0]      step_reg;
    logic [DIVISOR_W-1:0]   rem_reg;
    logic [DIVIDEND_W-1:0]  quo_reg;
    logic [DIVISOR_W-1:0]   div_reg;
    logic                   neg_reg;
    logic                   zero_reg;

    logic [DIVIDEND_W-1:0]  dvd_mag;
    logic [DIVISOR_W:0]     rem_sh;
    logic [DIVISOR_W:0]     rem_diff;
    logic                   ge;
    logic [QUOT_W-1:0]      mag;

    assign dvd_mag  = dividend[DIVIDEND_W-1] ? (~dividend + DIVIDEND_W'(1)) : dividend;
    assign rem_sh   = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign rem_diff = rem_sh - {1'b0, div_reg};
    assign ge       = (rem_sh >= {1'b0, div_reg});
    assign mag      = quo_reg[QUOT_W-1:0];

    assign busy     = busy_reg;
    assign quotient = zero_reg ? '0 : (neg_reg ? -$signed(mag) : $signed(mag));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= 1'b1;
        end else if (busy_reg && step_reg == STEP_W'(1)) begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            step_reg <= STEP_W'(DIVIDEND_W);
            rem_reg  <= '0;
            quo_reg  <= dvd_mag;
            div_reg  <= divisor;
            neg_reg  <= dividend[DIVIDEND_W-1];
            zero_reg <= (divisor == '0);
        end else if (busy_reg) begin
            step_reg <= step_reg - STEP_W'(1);
            rem_reg  <= ge ? rem_diff[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
            quo_reg  <= {quo_reg[DIVIDEND_W-2:0], ge};
        end
    end

endmodule
`default_nettype wire

// File: rtl/oma_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// oma_back: window close engine
// Divides the window sums, scans both rings for over-limit entries, writes
// the new averages and produces the alarm result.
// ----------------------------------------------------------------------------
module oma_back import oma_pkg::*; #(
    parameter int RING_DEPTH = 50,
    parameter int COUNT_BITS = 16,
    parameter int SUM_W      = 45
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          q_valid,
    output logic                               q_ready,
    input  wire logic [2*SUM_W+COUNT_BITS-1:0] q_data,
    input  wire limits_t                       limits,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic                               m_buzzer_on,
    output logic                               m_alarm,
    output logic [OVER_OUT_W-1:0]              m_high_over_count,
    output logic [OVER_OUT_W-1:0]              m_low_over_count,
    output logic signed [AVG_W-1:0]            m_high_avg_uw,
    output logic signed [AVG_W-1:0]            m_low_avg_uw
);

    localparam int PTR_W  = $clog2(RING_DEPTH);
    localparam int SCAN_W = $clog2(RING_DEPTH + 1);
    localparam int HALF   = RING_DEPTH / 2;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_RUN    = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0]               state_reg;
    logic [1:0]               state_next;

    logic [SUM_W-1:0]         q_high_sum;
    logic [SUM_W-1:0]         q_low_sum;
    logic [COUNT_BITS-1:0]    q_count;
    logic                     start;
    logic                     hi_busy;
    logic                     lo_busy;
    logic signed [AVG_W-1:0]  hi_quot;
    logic signed [AVG_W-1:0]  lo_quot;

    logic signed [AVG_W-1:0]  high_mem [RING_DEPTH];
    logic signed [AVG_W-1:0]  low_mem  [RING_DEPTH];
    logic [RING_DEPTH-1:0]    ring_valid_reg;
    logic [PTR_W-1:0]         ptr_reg;
    logic [PTR_W-1:0]         new_ptr_reg;
    logic [PTR_W-1:0]         ptr_inc;

    logic [SCAN_W-1:0]        scan_cnt_reg;
    logic                     scan_issue;
    logic [PTR_W-1:0]         scan_addr;
    logic                     rd_pend_reg;
    logic                     rd_vbit_reg;
    logic [PTR_W-1:0]         rd_idx_reg;
    logic signed [AVG_W-1:0]  hi_rd_reg;
    logic signed [AVG_W-1:0]  lo_rd_reg;
    logic                     hit_high;
    logic                     hit_low;
    logic [SCAN_W-1:0]        hi_cnt_reg;
    logic [SCAN_W-1:0]        lo_cnt_reg;

    logic signed [AVG_W-1:0]  lim_high_s;
    logic signed [AVG_W-1:0]  lim_low_s;
    logic [SCAN_W-1:0]        hi_total;
    logic [SCAN_W-1:0]        lo_total;
    logic                     alarm;
    logic                     finish_fire;
    logic                     run_done;

    logic                     m_valid_reg;
    logic                     buzzer_reg;
    logic                     alarm_out_reg;
    logic [OVER_OUT_W-1:0]    hi_over_out_reg;
    logic [OVER_OUT_W-1:0]    lo_over_out_reg;
    logic signed [AVG_W-1:0]  hi_avg_out_reg;
    logic signed [AVG_W-1:0]  lo_avg_out_reg;

    assign q_high_sum = q_data[2*SUM_W+COUNT_BITS-1 -: SUM_W];
    assign q_low_sum  = q_data[SUM_W+COUNT_BITS-1 -: SUM_W];
    assign q_count    = q_data[COUNT_BITS-1:0];
    assign q_ready    = (state_reg == ST_IDLE);
    assign start      = q_valid && q_ready;

    oma_divider #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (COUNT_BITS),
        .QUOT_W     (AVG_W)
    ) u_div_high (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start),
        .dividend (q_high_sum),
        .divisor  (q_count),
        .busy     (hi_busy),
        .quotient (hi_quot)
    );

    oma_divider #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (COUNT_BITS),
        .QUOT_W     (AVG_W)
    ) u_div_low (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start),
        .dividend (q_low_sum),
        .divisor  (q_count),
        .busy     (lo_busy),
        .quotient (lo_quot)
    );

    assign ptr_inc    = (ptr_reg == PTR_W'(RING_DEPTH - 1)) ? '0 : ptr_reg + PTR_W'(1);
    assign scan_issue = (state_reg == ST_RUN) && (scan_cnt_reg < SCAN_W'(RING_DEPTH));
    assign scan_addr  = scan_cnt_reg[PTR_W-1:0];

    assign lim_high_s = $signed({1'b0, limits.limit_high});
    assign lim_low_s  = $signed({1'b0, limits.limit_low});

    assign hit_high = rd_pend_reg && rd_vbit_reg && (rd_idx_reg != new_ptr_reg)
                   && (hi_rd_reg > lim_high_s);
    assign hit_low  = rd_pend_reg && rd_vbit_reg && (rd_idx_reg != new_ptr_reg)
                   && (lo_rd_reg > lim_low_s);

    assign run_done    = (state_reg == ST_RUN) && !scan_issue && !rd_pend_reg
                      && !hi_busy && !lo_busy;
    assign finish_fire = (state_reg == ST_FINISH) && (!m_valid_reg || m_ready);

    assign hi_total = hi_cnt_reg + SCAN_W'(hi_quot > lim_high_s);
    assign lo_total = lo_cnt_reg + SCAN_W'(lo_quot > lim_low_s);
    assign alarm    = (hi_total > SCAN_W'(HALF)) || (lo_total > SCAN_W'(HALF));

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (run_done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (finish_fire) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            scan_cnt_reg   <= '0;
            rd_pend_reg    <= 1'b0;
            hi_cnt_reg     <= '0;
            lo_cnt_reg     <= '0;
            ptr_reg        <= '0;
            new_ptr_reg    <= '0;
            ring_valid_reg <= '0;
            buzzer_reg     <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rd_pend_reg <= scan_issue;
            if (start) begin
                scan_cnt_reg <= '0;
                hi_cnt_reg   <= '0;
                lo_cnt_reg   <= '0;
                new_ptr_reg  <= ptr_inc;
            end else begin
                if (scan_issue) begin
                    scan_cnt_reg <= scan_cnt_reg + SCAN_W'(1);
                end
                hi_cnt_reg <= hi_cnt_reg + SCAN_W'(hit_high);
                lo_cnt_reg <= lo_cnt_reg + SCAN_W'(hit_low);
            end
            if (finish_fire) begin
                ptr_reg                     <= new_ptr_reg;
                ring_valid_reg[new_ptr_reg] <= 1'b1;
                buzzer_reg                  <= alarm ? ~buzzer_reg : 1'b0;
                m_valid_reg                 <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (finish_fire) begin
            high_mem[new_ptr_reg] <= hi_quot;
            low_mem[new_ptr_reg]  <= lo_quot;
        end
        if (scan_issue) begin
            hi_rd_reg   <= high_mem[scan_addr];
            lo_rd_reg   <= low_mem[scan_addr];
            rd_idx_reg  <= scan_addr;
            rd_vbit_reg <= ring_valid_reg[scan_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (finish_fire) begin
            alarm_out_reg   <= alarm;
            hi_over_out_reg <= OVER_OUT_W'(hi_total);
            lo_over_out_reg <= OVER_OUT_W'(lo_total);
            hi_avg_out_reg  <= hi_quot;
            lo_avg_out_reg  <= lo_quot;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_buzzer_on       = buzzer_reg;
    assign m_alarm           = alarm_out_reg;
    assign m_high_over_count = hi_over_out_reg;
    assign m_low_over_count  = lo_over_out_reg;
    assign m_high_avg_uw     = hi_avg_out_reg;
    assign m_low_avg_uw      = lo_avg_out_reg;

endmodule
`default_nettype wire

// File: rtl/overpower_majority_alarm_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// overpower_majority_alarm_top: regulator overdissipation majority alarm
// Each s_ beat carries one sample of both rails; s_mode = 1 also closes the
// window and yields one m_ beat with the averages, the over-limit counts of
// both rings and the buzzer level. Samples with s_mode = 0 yield no beat.
// The user writes registers through the cfg_ channel while the block is
// idle; the block itself does not enforce this. Index 0/1 nominal high/low
// rail input voltage, 2/3 high/low rail limits. Sample beats are taken one
// per cycle while s_ready is high. A closing beat is queued (two deep) and
// worked off by the back unit: its two serial dividers, on a dividend of
// SUM_W = 29 + COUNT_BITS bits, run alongside the ring scan, and it takes a
// new window only once the last result has gone to the output register;
// sampling continues meanwhile.
// The result is held in an output register until m_ready; while it waits the
// back unit finishes the next window and then stalls, the queue fills and
// s_ready drops. Reset clears the sums, count, ring pointer, buzzer and ring
// valid bits, so the ring reads as all zero and no beat is pending.
// ----------------------------------------------------------------------------
module overpower_majority_alarm_top import oma_pkg::*; #(
    parameter int RING_DEPTH = 50,
    parameter int COUNT_BITS = 16
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic                  s_mode,
    input  wire logic [MV_W-1:0]       s_high_rail_mv,
    input  wire logic [MA_W-1:0]       s_high_rail_ma,
    input  wire logic [MV_W-1:0]       s_low_rail_mv,
    input  wire logic [MA_W-1:0]       s_low_rail_ma,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic                       m_buzzer_on,
    output logic                       m_alarm,
    output logic [OVER_OUT_W-1:0]      m_high_over_count,
    output logic [OVER_OUT_W-1:0]      m_low_over_count,
    output logic signed [AVG_W-1:0]    m_high_avg_uw,
    output logic signed [AVG_W-1:0]    m_low_avg_uw,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int SUM_W   = PROD_W - 1 + COUNT_BITS;
    localparam int ENTRY_W = 2 * SUM_W + COUNT_BITS;

    nominal_t            nominal_reg;
    limits_t             limits_reg;
    logic                q_push_valid;
    logic                q_push_ready;
    logic [ENTRY_W-1:0]  q_push_data;
    logic                q_pop_valid;
    logic                q_pop_ready;
    logic [ENTRY_W-1:0]  q_pop_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nominal_reg.nominal_high <= RST_NOMINAL_HIGH;
            nominal_reg.nominal_low  <= RST_NOMINAL_LOW;
            limits_reg.limit_high    <= RST_LIMIT_HIGH;
            limits_reg.limit_low     <= RST_LIMIT_LOW;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_NOMINAL_HIGH: nominal_reg.nominal_high <= cfg_data[MV_W-1:0];
                CFG_NOMINAL_LOW:  nominal_reg.nominal_low  <= cfg_data[MV_W-1:0];
                CFG_LIMIT_HIGH:   limits_reg.limit_high    <= cfg_data[LIMIT_W-1:0];
                CFG_LIMIT_LOW:    limits_reg.limit_low     <= cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    oma_front #(
        .COUNT_BITS (COUNT_BITS),
        .SUM_W      (SUM_W)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_mode         (s_mode),
        .s_high_rail_mv (s_high_rail_mv),
        .s_high_rail_ma (s_high_rail_ma),
        .s_low_rail_mv  (s_low_rail_mv),
        .s_low_rail_ma  (s_low_rail_ma),
        .nominal        (nominal_reg),
        .q_valid        (q_push_valid),
        .q_ready        (q_push_ready),
        .q_data         (q_push_data)
    );

    oma_queue #(
        .DATA_W (ENTRY_W)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_data  (q_push_data),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_data   (q_pop_data)
    );

    oma_back #(
        .RING_DEPTH (RING_DEPTH),
        .COUNT_BITS (COUNT_BITS),
        .SUM_W      (SUM_W)
    ) u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .q_valid           (q_pop_valid),
        .q_ready           (q_pop_ready),
        .q_data            (q_pop_data),
        .limits            (limits_reg),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_buzzer_on       (m_buzzer_on),
        .m_alarm           (m_alarm),
        .m_high_over_count (m_high_over_count),
        .m_low_over_count  (m_low_over_count),
        .m_high_avg_uw     (m_high_avg_uw),
        .m_low_avg_uw      (m_low_avg_uw)
    );

`ifndef NO_ASSERTIONS
    a_buzzer_needs_alarm: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_buzzer_on |-> m_alarm)
        else $error("buzzer on without alarm");

    a_reset_no_beat: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result beat pending after reset");

    a_sample_not_queued: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !s_mode |=> !q_push_valid || $stable(q_push_data)
            || !$past(q_push_valid))
        else $error("sample beat pushed a window");
`endif

endmodule
`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for overpower_majority_alarm_top
// Drives rail samples and register writes over valid/ready channels with
// random idling and back-pressure, predicts every window result (averages,
// ring over-limit counts, alarm, buzzer) and compares each m_ beat with the
// oldest prediction.
// ----------------------------------------------------------------------------
module tb;
    import oma_pkg::*;

    localparam int          RING_DEPTH    = 50;
    localparam int          COUNT_BITS    = 16;
    localparam int unsigned COUNT_CAP     = (1 << COUNT_BITS) - 1;
    localparam int          SETTLE_CYCLES = 100;
    localparam int          DRAIN_LIMIT   = 20000;
    localparam int          LONG_STALL    = 400;
    localparam int          IDLE_PCT      = 16;
    localparam int          PRINT_LIMIT   = 200;

    typedef enum logic {
        MODE_ACCUMULATE = 1'b0,
        MODE_CLOSE      = 1'b1
    } mode_e;

    typedef struct packed {
        mode_e           mode;
        logic [MV_W-1:0] high_mv;
        logic [MA_W-1:0] high_ma;
        logic [MV_W-1:0] low_mv;
        logic [MA_W-1:0] low_ma;
    } sample_t;

    typedef struct packed {
        logic                    buzzer_on;
        logic                    alarm;
        logic [OVER_OUT_W-1:0]   high_over;
        logic [OVER_OUT_W-1:0]   low_over;
        logic signed [AVG_W-1:0] high_avg;
        logic signed [AVG_W-1:0] low_avg;
    } window_result_t;

    class alarm_predictor;
        logic [MV_W-1:0]    nominal_high;
        logic [MV_W-1:0]    nominal_low;
        logic [LIMIT_W-1:0] limit_high;
        logic [LIMIT_W-1:0] limit_low;
        longint             high_sum;
        longint             low_sum;
        int unsigned        sample_count;
        int                 high_ring[RING_DEPTH];
        int                 low_ring[RING_DEPTH];
        int unsigned        ring_ptr;
        bit                 buzzer;
        window_result_t     expected_windows[$];
        int unsigned        errors;
        int unsigned        windows_seen;

        function new();
            nominal_high = RST_NOMINAL_HIGH;
            nominal_low  = RST_NOMINAL_LOW;
            limit_high   = RST_LIMIT_HIGH;
            limit_low    = RST_LIMIT_LOW;
            high_sum     = 0;
            low_sum      = 0;
            sample_count = 0;
            ring_ptr     = 0;
            buzzer       = 1'b0;
            errors       = 0;
            windows_seen = 0;
            foreach (high_ring[k]) begin
                high_ring[k] = 0;
                low_ring[k]  = 0;
            end
        endfunction

        function void take_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_NOMINAL_HIGH: nominal_high = data[MV_W-1:0];
                CFG_NOMINAL_LOW:  nominal_low  = data[MV_W-1:0];
                CFG_LIMIT_HIGH:   limit_high   = data[LIMIT_W-1:0];
                CFG_LIMIT_LOW:    limit_low    = data[LIMIT_W-1:0];
                default: ;
            endcase
        endfunction

        function longint rail_loss(logic [MV_W-1:0] nominal, logic [MV_W-1:0] mv,
                                   logic [MA_W-1:0] ma);
            return (longint'(nominal) - longint'(mv)) * longint'(ma);
        endfunction

        function void take_sample(sample_t smp);
            window_result_t res;
            longint         high_avg;
            longint         low_avg;
            int unsigned    high_over;
            int unsigned    low_over;
            bit             alarm;
            if (sample_count < COUNT_CAP) begin
                high_sum += rail_loss(nominal_high, smp.high_mv, smp.high_ma);
                low_sum  += rail_loss(nominal_low, smp.low_mv, smp.low_ma);
                sample_count++;
            end
            if (smp.mode != MODE_CLOSE) return;
            high_avg = (sample_count == 0) ? 0 : high_sum / longint'(sample_count);
            low_avg  = (sample_count == 0) ? 0 : low_sum / longint'(sample_count);
            ring_ptr = (ring_ptr + 1) % RING_DEPTH;
            high_ring[ring_ptr] = int'(high_avg);
            low_ring[ring_ptr]  = int'(low_avg);
            high_sum     = 0;
            low_sum      = 0;
            sample_count = 0;
            high_over    = 0;
            low_over     = 0;
            for (int k = 0; k < RING_DEPTH; k++) begin
                if (longint'(high_ring[k]) > longint'(limit_high)) high_over++;
                if (longint'(low_ring[k]) > longint'(limit_low)) low_over++;
            end
            alarm = (high_over > RING_DEPTH / 2) || (low_over > RING_DEPTH / 2);
            buzzer = alarm ? ~buzzer : 1'b0;
            res.buzzer_on = buzzer;
            res.alarm     = alarm;
            res.high_over = high_over[OVER_OUT_W-1:0];
            res.low_over  = low_over[OVER_OUT_W-1:0];
            res.high_avg  = AVG_W'(high_avg);
            res.low_avg   = AVG_W'(low_avg);
            expected_windows.push_back(res);
        endfunction

        task report(string msg);
            if (errors < PRINT_LIMIT) $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        task compare_field(string name, logic signed [63:0] want, logic signed [63:0] got);
            if (got !== want)
                report($sformatf("window %0d %s expected %0d got %0d",
                                 windows_seen, name, want, got));
        endtask

        task check_window(window_result_t got);
            window_result_t want;
            if (expected_windows.size() == 0) begin
                report($sformatf("result beat with no window closed (avg %0d / %0d)",
                                 got.high_avg, got.low_avg));
                return;
            end
            want = expected_windows.pop_front();
            compare_field("buzzer_on", want.buzzer_on, got.buzzer_on);
            compare_field("alarm", want.alarm, got.alarm);
            compare_field("high_over_count", want.high_over, got.high_over);
            compare_field("low_over_count", want.low_over, got.low_over);
            compare_field("high_avg_uw", want.high_avg, got.high_avg);
            compare_field("low_avg_uw", want.low_avg, got.low_avg);
            windows_seen++;
        endtask

        task report_leftovers();
            while (expected_windows.size() != 0) begin
                report($sformatf("window %0d never came out", windows_seen));
                void'(expected_windows.pop_front());
                windows_seen++;
            end
        endtask
    endclass

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic                    s_mode = 1'b0;
    logic [MV_W-1:0]         s_high_rail_mv = '0;
    logic [MA_W-1:0]         s_high_rail_ma = '0;
    logic [MV_W-1:0]         s_low_rail_mv = '0;
    logic [MA_W-1:0]         s_low_rail_ma = '0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic                    m_buzzer_on;
    logic                    m_alarm;
    logic [OVER_OUT_W-1:0]   m_high_over_count;
    logic [OVER_OUT_W-1:0]   m_low_over_count;
    logic signed [AVG_W-1:0] m_high_avg_uw;
    logic signed [AVG_W-1:0] m_low_avg_uw;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;

    alarm_predictor model;
    bit             no_idle = 1'b0;
    bit             stall_request = 1'b0;

    overpower_majority_alarm_top #(
        .RING_DEPTH(RING_DEPTH),
        .COUNT_BITS(COUNT_BITS)
    ) u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_mode            (s_mode),
        .s_high_rail_mv    (s_high_rail_mv),
        .s_high_rail_ma    (s_high_rail_ma),
        .s_low_rail_mv     (s_low_rail_mv),
        .s_low_rail_ma     (s_low_rail_ma),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_buzzer_on       (m_buzzer_on),
        .m_alarm           (m_alarm),
        .m_high_over_count (m_high_over_count),
        .m_low_over_count  (m_low_over_count),
        .m_high_avg_uw     (m_high_avg_uw),
        .m_low_avg_uw      (m_low_avg_uw),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // receiver: random back-pressure, one long hold-off on request
    initial begin : result_sink
        forever begin
            @(posedge aclk);
            if (stall_request) begin
                stall_request = 1'b0;
                m_ready <= 1'b0;
                repeat (LONG_STALL) @(posedge aclk);
            end
            m_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge aclk) begin : result_monitor
        window_result_t got;
        if (aresetn && m_valid && m_ready) begin
            got.buzzer_on = m_buzzer_on;
            got.alarm     = m_alarm;
            got.high_over = m_high_over_count;
            got.low_over  = m_low_over_count;
            got.high_avg  = m_high_avg_uw;
            got.low_avg   = m_low_avg_uw;
            model.check_window(got);
        end
    end

    function automatic sample_t sample_of(mode_e mode, int unsigned hmv, int unsigned hma,
                                          int unsigned lmv, int unsigned lma);
        sample_t smp;
        smp.mode    = mode;
        smp.high_mv = MV_W'(hmv);
        smp.high_ma = MA_W'(hma);
        smp.low_mv  = MV_W'(lmv);
        smp.low_ma  = MA_W'(lma);
        return smp;
    endfunction

    function automatic sample_t rand_sample(bit hot, mode_e mode);
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 15)
            return sample_of(mode, $urandom, $urandom, $urandom, $urandom);
        if (hot)
            return sample_of(mode, $urandom_range(0, 3000), $urandom_range(10000, 16383),
                             $urandom_range(0, 3000), $urandom_range(10000, 16383));
        return sample_of(mode, $urandom, $urandom_range(0, 2000),
                         $urandom, $urandom_range(0, 2000));
    endfunction

    // hold valid across back-to-back beats; drop it only for an idle gap
    task automatic offer_sample(sample_t smp);
        if (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < IDLE_PCT) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_mode         <= smp.mode;
        s_high_rail_mv <= smp.high_mv;
        s_high_rail_ma <= smp.high_ma;
        s_low_rail_mv  <= smp.low_mv;
        s_low_rail_ma  <= smp.low_ma;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        model.take_sample(smp);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        model.take_register(idx, data);
    endtask

    task automatic apply_settings(logic [MV_W-1:0] nom_high, logic [MV_W-1:0] nom_low,
                                  logic [LIMIT_W-1:0] lim_high, logic [LIMIT_W-1:0] lim_low);
        logic [CFG_DATA_W-1:0] data;
        data = CFG_DATA_W'($urandom);
        data[MV_W-1:0] = nom_high;
        write_reg(CFG_NOMINAL_HIGH, data);
        data = CFG_DATA_W'($urandom);
        data[MV_W-1:0] = nom_low;
        write_reg(CFG_NOMINAL_LOW, data);
        write_reg(CFG_LIMIT_HIGH, lim_high);
        write_reg(CFG_LIMIT_LOW, lim_low);
        for (int idx = CFG_LIMIT_LOW + 1; idx < 2 ** CFG_IDX_W; idx++)
            write_reg(CFG_IDX_W'(idx), CFG_DATA_W'($urandom));
        cfg_valid <= 1'b0;
    endtask

    // stop offering, wait out every pending window, then let the back unit go quiet
    task automatic drain();
        int unsigned waited;
        waited = 0;
        s_valid <= 1'b0;
        while (model.expected_windows.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic run_windows(int unsigned n_items, int unsigned hot_pct, int unsigned max_len);
        int unsigned sent;
        int unsigned len;
        bit          hot;
        sent = 0;
        while (sent < n_items) begin
            len = $urandom_range(1, max_len);
            if (max_len > 1 && $urandom_range(19) == 0) len = $urandom_range(1, 8 * max_len);
            hot = ($urandom_range(99) < hot_pct);
            for (int i = 0; i < len; i++) begin
                offer_sample(rand_sample(hot, (i == len - 1) ? MODE_CLOSE : MODE_ACCUMULATE));
                sent++;
            end
        end
    endtask

    task automatic directed_samples();
        offer_sample(sample_of(MODE_CLOSE, 0, 0, 0, 0));
        offer_sample(sample_of(MODE_CLOSE, 0, 16383, 0, 16383));
        offer_sample(sample_of(MODE_CLOSE, 16383, 16383, 16383, 16383));
        offer_sample(sample_of(MODE_CLOSE, 16383, 0, 16383, 0));
        // negative sum, average truncates toward zero
        offer_sample(sample_of(MODE_ACCUMULATE, 12003, 1, 5003, 1));
        offer_sample(sample_of(MODE_CLOSE, 12000, 5, 5000, 5));
        offer_sample(sample_of(MODE_ACCUMULATE, 12001, 3, 5002, 3));
        offer_sample(sample_of(MODE_ACCUMULATE, 12000, 0, 5000, 0));
        offer_sample(sample_of(MODE_CLOSE, 11999, 1, 4999, 1));
        offer_sample(sample_of(MODE_ACCUMULATE, 0, 16383, 16383, 0));
        offer_sample(sample_of(MODE_ACCUMULATE, 16383, 16383, 0, 16383));
        offer_sample(sample_of(MODE_CLOSE, 12000, 16383, 5000, 16383));
        offer_sample(sample_of(MODE_CLOSE, 'h2AAA, 'h1555, 'h1555, 'h2AAA));
        offer_sample(sample_of(MODE_CLOSE, 'h1555, 'h2AAA, 'h2AAA, 'h1555));
        offer_sample(sample_of(MODE_ACCUMULATE, 'h2AAA, 'h2AAA, 'h1555, 'h1555));
        offer_sample(sample_of(MODE_CLOSE, 'h1555, 'h1555, 'h2AAA, 'h2AAA));
    endtask

    initial begin : stimulus
        model = new();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        directed_samples();
        run_windows(250, 90, 6);
        drain();

        apply_settings(16383, 0, 0, 268435455);
        run_windows(200, 50, 6);
        drain();

        apply_settings(0, 16383, 268435455, 0);
        run_windows(200, 30, 6);
        drain();

        apply_settings(MV_W'($urandom), MV_W'($urandom), LIMIT_W'($urandom_range(0, 200000000)),
                       LIMIT_W'($urandom_range(0, 100000000)));
        no_idle = 1'b1;
        run_windows(200, 60, 6);
        no_idle = 1'b0;
        drain();

        apply_settings(RST_NOMINAL_HIGH, RST_NOMINAL_LOW, RST_LIMIT_HIGH, RST_LIMIT_LOW);
        stall_request = 1'b1;
        run_windows(60, 70, 1);
        drain();

        run_windows(250, 10, 6);
        drain();

        apply_settings(RST_NOMINAL_HIGH, RST_NOMINAL_LOW, LIMIT_W'($urandom_range(0, 90000000)),
                       LIMIT_W'($urandom_range(0, 45000000)));
        run_windows(250, 50, 8);
        drain();

        model.report_leftovers();
        if (model.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #15_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: files.f
rtl/oma_pkg.sv
rtl/oma_queue.sv
rtl/oma_front.sv
rtl/oma_divider.sv
rtl/oma_back.sv
rtl/overpower_majority_alarm_top.sv
tb/tb.sv
